>>> src/sshd_pkg.sv
// Shared constants for the multiplexed three-digit seven-segment scanner.
package sshd_pkg;

  // Default counter width for the per-digit dwell counter.
  localparam int unsigned DWELL_WIDTH_DEF = 16;

  // Width of the dwell configuration register.
  localparam int unsigned CFG_W = 16;

  // Dwell register value after reset.
  localparam logic [CFG_W-1:0] DWELL_RESET = 16'd3;

  // Active-low anode codes: bit2 left, bit1 center, bit0 right.
  localparam logic [2:0] ANODE_LEFT   = 3'b011;
  localparam logic [2:0] ANODE_CENTER = 3'b101;
  localparam logic [2:0] ANODE_RIGHT  = 3'b110;

  // Scan phase codes (index of the lit digit).
  localparam logic [1:0] PHASE_FIRST  = 2'd0;
  localparam logic [1:0] PHASE_SECOND = 2'd1;
  localparam logic [1:0] PHASE_THIRD  = 2'd2;

  // Digits per scan in each mode.
  localparam logic [1:0] DIGITS_HEX = 2'd2;
  localparam logic [1:0] DIGITS_DEC = 2'd3;

  // Active-low segment patterns, bit order DP,C,G,D,B,F,A,E.
  localparam logic [7:0] SEG_TABLE [16] = '{
    8'd160, 8'd183, 8'd196, 8'd133, 8'd147, 8'd137, 8'd136, 8'd177,
    8'd128, 8'd129, 8'd144, 8'd138, 8'd232, 8'd134, 8'd200, 8'd216
  };

endpackage

>>> src/seven_segment_hex_dec_scanner.sv
// Three-digit multiplexed seven-segment scanner, top level.
// A tick word's segment/anode word is loaded into the result register when the word is accepted.
// Throughput: one tick word per cycle; a single result register splits the two sides,
//   so input is taken whenever that register is empty or being drained in the same cycle.
// Reset: rst_ni (async, active low) clears scan phase, dwell counter, latched byte/mode,
//   sets the dwell register to 3 and empties the result register; no clearing pass.
module seven_segment_hex_dec_scanner #(
  parameter int unsigned DWELL_WIDTH = sshd_pkg::DWELL_WIDTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration: dwell ticks per digit
  input  logic                       cfg_we_i,
  input  logic [sshd_pkg::CFG_W-1:0] cfg_wdata_i,
  // tick words in
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [7:0]                 data_value_i,
  input  logic                       hex_mode_i,
  // display words out
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [7:0]                 segment_lines_o,
  output logic [2:0]                 anode_lines_o
);
  import sshd_pkg::*;

  // Compare width wide enough for both the counter and the register.
  localparam int unsigned CMP_W = (DWELL_WIDTH > CFG_W) ? DWELL_WIDTH : CFG_W;

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0]       dwell_q;
  logic [1:0]             phase_q, phase_d;
  logic [DWELL_WIDTH-1:0] cnt_q, cnt_d;
  logic [7:0]             lat_val_q, lat_val_d;
  logic                   lat_mode_q, lat_mode_d;

  logic                   out_valid_q;
  logic [7:0]             seg_q, seg_d;
  logic [2:0]             anode_q, anode_d;

  logic                   in_fire;
  logic                   out_fire;

  assign out_fire   = out_valid_q && !out_stall_i;
  // Take a new word whenever the result register is empty or frees up this cycle.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_fire    = in_valid_i && !in_stall_o;

  // ---------------------------------------------------------------------------
  // Scan step
  // ---------------------------------------------------------------------------
  logic [1:0]             digits_old, digits_new;
  logic                   stray;
  logic [1:0]             phase_eff;
  logic [DWELL_WIDTH-1:0] cnt_eff, cnt_inc;
  logic                   latch;
  logic                   wrap;
  logic [1:0]             phase_inc;

  // decimal split
  logic [1:0]             hund;
  logic [6:0]             rem100;
  logic [14:0]            prod;
  logic [3:0]             tens;
  logic [3:0]             units;
  logic [3:0]             digit;

  always_comb begin
    digits_old = lat_mode_q ? DIGITS_HEX : DIGITS_DEC;
    // A phase past the end of the scan restarts the scan.
    stray      = (phase_q >= digits_old);
    phase_eff  = stray ? PHASE_FIRST : phase_q;
    cnt_eff    = stray ? '0 : cnt_q;

    // Latch byte and mode on the first tick of a scan.
    latch      = (phase_eff == PHASE_FIRST) && (cnt_eff == '0);
    lat_val_d  = latch ? data_value_i : lat_val_q;
    lat_mode_d = latch ? hex_mode_i : lat_mode_q;
    digits_new = lat_mode_d ? DIGITS_HEX : DIGITS_DEC;

    // Hundreds by compare, then tens by reciprocal multiply (205/2048 exact below 100).
    if (lat_val_d >= 8'd200) begin
      hund   = 2'd2;
      rem100 = 7'(lat_val_d - 8'd200);
    end else if (lat_val_d >= 8'd100) begin
      hund   = 2'd1;
      rem100 = 7'(lat_val_d - 8'd100);
    end else begin
      hund   = 2'd0;
      rem100 = lat_val_d[6:0];
    end
    prod  = 15'(rem100) * 15'd205;
    tens  = prod[14:11];
    units = 4'(rem100 - 7'({3'b000, tens} * 7'd10));

    // Select the lit digit and its anode.
    if (lat_mode_d) begin
      if (phase_eff == PHASE_FIRST) begin
        digit   = lat_val_d[7:4];
        anode_d = ANODE_CENTER;
      end else begin
        digit   = lat_val_d[3:0];
        anode_d = ANODE_RIGHT;
      end
    end else begin
      case (phase_eff)
        PHASE_FIRST: begin
          digit   = {2'b00, hund};
          anode_d = ANODE_LEFT;
        end
        PHASE_SECOND: begin
          digit   = tens;
          anode_d = ANODE_CENTER;
        end
        default: begin
          digit   = units;
          anode_d = ANODE_RIGHT;
        end
      endcase
    end
    seg_d = SEG_TABLE[digit];

    // Advance the dwell counter; a zero dwell acts as one, and a dwell past the
    // counter range ends the digit only when the counter wraps.
    cnt_inc   = cnt_eff + 1'b1;
    wrap      = (cnt_inc == '0) || (CMP_W'(cnt_inc) >= CMP_W'(dwell_q));
    phase_inc = phase_eff + 2'd1;
    if (wrap) begin
      cnt_d   = '0;
      phase_d = (phase_inc >= digits_new) ? PHASE_FIRST : phase_inc;
    end else begin
      cnt_d   = cnt_inc;
      phase_d = phase_eff;
    end
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dwell_q     <= DWELL_RESET;
      phase_q     <= PHASE_FIRST;
      cnt_q       <= '0;
      lat_val_q   <= '0;
      lat_mode_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        dwell_q <= cfg_wdata_i;
      end
      if (in_fire) begin
        phase_q    <= phase_d;
        cnt_q      <= cnt_d;
        lat_val_q  <= lat_val_d;
        lat_mode_q <= lat_mode_d;
      end
      // Hold the result while stalled, drop it once taken.
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload of the result register: load on accept only.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      seg_q   <= seg_d;
      anode_q <= anode_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign segment_lines_o = seg_q;
  assign anode_lines_o   = anode_q;

`ifndef SYNTHESIS
  // Exactly one digit is lit in every result word.
  a_one_anode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ($countones(anode_lines_o) == 2))
    else $error("anode word does not light exactly one digit");

  // An accepted tick always leaves a result waiting in the next cycle.
  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_q)
    else $error("accepted tick produced no result");

  // Phase never leaves the digit range of the latched mode.
  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q < digits_old)
    else $error("scan phase outside the digit range");

  // A move to the next digit always restarts the dwell counter.
  a_phase_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(phase_q) |-> (cnt_q == '0))
    else $error("digit changed without clearing the dwell counter");
`endif

endmodule
